// ===== hdl/expression_tokenizer_macros.svh =====
// Assertion macros shared by the tokenizer modules.
// Each macro expects a clock named clk and a reset named arst_n in scope.
`ifndef EXPRESSION_TOKENIZER_MACROS_SVH
`define EXPRESSION_TOKENIZER_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define EXPTOK_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// The antecedent implies the consequent on the following clock edge.
`define EXPTOK_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/exptok_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package exptok_pkg;

	localparam int MAX_RES = 3;
	localparam int CNT_W   = $clog2(MAX_RES + 1);

	typedef enum logic [2:0] {
		MODE_IDLE = 3'd0,
		MODE_NAME = 3'd1,
		MODE_PATH = 3'd2,
		MODE_INT  = 3'd3,
		MODE_REAL = 3'd4,
		MODE_OPER = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		OP_PLUS  = 2'd0,
		OP_MINUS = 2'd1,
		OP_MUL   = 2'd2,
		OP_DIV   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		EV_APPEND   = 2'd0,
		EV_COMPLETE = 2'd1,
		EV_ERROR    = 2'd2
	} event_t;

	localparam logic [3:0] TT_INT    = 4'd0;
	localparam logic [3:0] TT_REAL   = 4'd1;
	localparam logic [3:0] TT_NAME   = 4'd2;
	localparam logic [3:0] TT_PATH   = 4'd3;
	localparam logic [3:0] TT_PLUS   = 4'd4;
	localparam logic [3:0] TT_DOT    = 4'd8;
	localparam logic [3:0] TT_LPAREN = 4'd9;
	localparam logic [3:0] TT_RPAREN = 4'd10;
	localparam logic [3:0] TT_COMMA  = 4'd11;
	localparam logic [3:0] TT_NONE   = 4'd0;

	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CH_USCORE = 8'h5F;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_NUL    = 8'h00;

	typedef struct packed {
		event_t      ev;
		logic [7:0]  ch;
		logic [3:0]  ty;
		logic        last;
	} res_t;

	typedef struct packed {
		logic [CNT_W-1:0]       cnt;
		res_t [MAX_RES-1:0]     res;
	} res_load_t;

	typedef struct packed {
		mode_t mode;
		op_t   pend;
		logic  err;
	} lex_state_t;

endpackage

`default_nettype wire

// ===== hdl/exptok_char_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface exptok_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       end_of_string;

	modport source (output valid, output character, output end_of_string, input ready);
	modport sink (input valid, input character, input end_of_string, output ready);
endinterface

`default_nettype wire

// ===== hdl/exptok_tok_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface exptok_tok_if;
	logic       valid;
	logic       ready;
	logic [1:0] event_res;
	logic [7:0] token_char;
	logic [3:0] token_type;
	logic       last_of_run;

	modport source (output valid, output event_res, output token_char, output token_type,
		output last_of_run, input ready);
	modport sink (input valid, input event_res, input token_char, input token_type,
		input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== hdl/exptok_lex.sv =====
`timescale 1ns / 1ps
`default_nettype none

module exptok_lex import exptok_pkg::*; (
	input  wire logic [7:0] character,
	input  wire logic       end_of_string,
	input  wire lex_state_t cur,
	output lex_state_t      nxt,
	output res_load_t       ld
);

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
			((c >= CH_LOWER_A) && (c <= CH_LOWER_Z));
	endfunction

	function automatic logic is_word(input logic [7:0] c);
		return is_digit(c) || is_letter(c) || (c == CH_USCORE);
	endfunction

	function automatic logic is_white(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF);
	endfunction

	function automatic logic is_oper(input logic [7:0] c);
		return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH);
	endfunction

	function automatic op_t oper_code(input logic [7:0] c);
		op_t op;
		case (c)
			CH_PLUS:  op = OP_PLUS;
			CH_MINUS: op = OP_MINUS;
			CH_STAR:  op = OP_MUL;
			default:  op = OP_DIV;
		endcase
		return op;
	endfunction

	function automatic logic [3:0] open_type(input mode_t m, input op_t p);
		logic [3:0] t;
		case (m)
			MODE_NAME: t = TT_NAME;
			MODE_PATH: t = TT_PATH;
			MODE_INT:  t = TT_INT;
			MODE_REAL: t = TT_REAL;
			default:   t = 4'(TT_PLUS + {2'b00, p});
		endcase
		return t;
	endfunction

	function automatic res_t mk_res(input event_t e, input logic [7:0] c, input logic [3:0] t);
		res_t r;
		r.ev   = e;
		r.ch   = c;
		r.ty   = t;
		r.last = 1'b0;
		return r;
	endfunction

	logic [7:0]        c;
	logic              rescan;
	logic [CNT_W-1:0]  n;
	res_t [MAX_RES-1:0] res;
	lex_state_t        st;

	assign c = character;

	always_comb begin
		res    = '0;
		n      = '0;
		st     = cur;
		rescan = 1'b0;
		if (!cur.err) begin
			case (cur.mode)
				MODE_NAME: begin
					if (is_word(c)) begin
						res[n] = mk_res(EV_APPEND, c, TT_NONE);
						n = n + 1'b1;
					end else if (c == CH_SLASH) begin
						res[n] = mk_res(EV_APPEND, c, TT_NONE);
						n = n + 1'b1;
						st.mode = MODE_PATH;
					end else begin
						rescan = 1'b1;
					end
				end
				MODE_PATH: begin
					if (is_word(c) || (c == CH_SLASH)) begin
						res[n] = mk_res(EV_APPEND, c, TT_NONE);
						n = n + 1'b1;
					end else begin
						rescan = 1'b1;
					end
				end
				MODE_INT, MODE_REAL: begin
					if (is_digit(c)) begin
						res[n] = mk_res(EV_APPEND, c, TT_NONE);
						n = n + 1'b1;
					end else if ((cur.mode == MODE_INT) && (c == CH_DOT)) begin
						res[n] = mk_res(EV_APPEND, c, TT_NONE);
						n = n + 1'b1;
						st.mode = MODE_REAL;
					end else if (is_white(c) || (c == CH_RPAREN) || is_oper(c) ||
							(c == CH_COMMA)) begin
						rescan = 1'b1;
					end else begin
						res[n] = mk_res(EV_ERROR, c, TT_NONE);
						n = n + 1'b1;
						st.mode = MODE_IDLE;
						st.pend = OP_PLUS;
						st.err  = 1'b1;
					end
				end
				MODE_OPER: begin
					if ((cur.pend == OP_DIV) && is_word(c)) begin
						res[n] = mk_res(EV_APPEND, c, TT_NONE);
						n = n + 1'b1;
						st.mode = MODE_PATH;
						st.pend = OP_PLUS;
					end else begin
						rescan = 1'b1;
					end
				end
				default: begin
					st.mode = MODE_IDLE;
				end
			endcase

			// A terminator closes the open token and is examined again from idle.
			if (rescan) begin
				res[n] = mk_res(EV_COMPLETE, CH_NUL, open_type(cur.mode, cur.pend));
				n = n + 1'b1;
				st.mode = MODE_IDLE;
				st.pend = OP_PLUS;
			end

			if (rescan || (st.mode == MODE_IDLE && !st.err)) begin
				if (is_letter(c)) begin
					res[n] = mk_res(EV_APPEND, c, TT_NONE);
					n = n + 1'b1;
					st.mode = MODE_NAME;
				end else if (is_digit(c)) begin
					res[n] = mk_res(EV_APPEND, c, TT_NONE);
					n = n + 1'b1;
					st.mode = MODE_INT;
				end else if (is_oper(c)) begin
					res[n] = mk_res(EV_APPEND, c, TT_NONE);
					n = n + 1'b1;
					st.mode = MODE_OPER;
					st.pend = oper_code(c);
				end else if (is_white(c)) begin
					st.mode = MODE_IDLE;
				end else if ((c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_DOT) ||
						(c == CH_COMMA)) begin
					res[n] = mk_res(EV_APPEND, c, TT_NONE);
					n = n + 1'b1;
					case (c)
						CH_LPAREN: res[n] = mk_res(EV_COMPLETE, CH_NUL, TT_LPAREN);
						CH_RPAREN: res[n] = mk_res(EV_COMPLETE, CH_NUL, TT_RPAREN);
						CH_DOT:    res[n] = mk_res(EV_COMPLETE, CH_NUL, TT_DOT);
						default:   res[n] = mk_res(EV_COMPLETE, CH_NUL, TT_COMMA);
					endcase
					n = n + 1'b1;
				end else begin
					res[n] = mk_res(EV_ERROR, c, TT_NONE);
					n = n + 1'b1;
					st.mode = MODE_IDLE;
					st.pend = OP_PLUS;
					st.err  = 1'b1;
				end
			end

			if (end_of_string && !st.err && (st.mode != MODE_IDLE)) begin
				res[n] = mk_res(EV_COMPLETE, CH_NUL, open_type(st.mode, st.pend));
				n = n + 1'b1;
			end
		end

		if (end_of_string) begin
			st.mode = MODE_IDLE;
			st.pend = OP_PLUS;
			st.err  = 1'b0;
		end

		for (int i = 0; i < MAX_RES; i++) begin
			res[i].last = (n != '0) && (CNT_W'(i) == (n - 1'b1));
		end
	end

	assign nxt    = st;
	assign ld.cnt = n;
	assign ld.res = res;

endmodule

`default_nettype wire

// ===== hdl/exptok_rbuf.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "expression_tokenizer_macros.svh"

module exptok_rbuf import exptok_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      load,
	input  wire res_load_t ld,
	output logic           free,
	exptok_tok_if.source   tokens
);

	res_t             buf_q [MAX_RES];
	logic [CNT_W-1:0] rem_q;
	logic             fire;

	assign tokens.valid       = (rem_q != '0);
	assign tokens.event_res   = buf_q[0].ev;
	assign tokens.token_char  = buf_q[0].ch;
	assign tokens.token_type  = buf_q[0].ty;
	assign tokens.last_of_run = buf_q[0].last;

	assign fire = tokens.valid && tokens.ready;
	assign free = (rem_q == '0) || ((rem_q == CNT_W'(1)) && tokens.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (load) begin
			rem_q <= ld.cnt;
		end else if (fire) begin
			rem_q <= rem_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < MAX_RES; i++) begin
				buf_q[i] <= ld.res[i];
			end
		end else if (fire) begin
			for (int i = 0; i < MAX_RES - 1; i++) begin
				buf_q[i] <= buf_q[i + 1];
			end
		end
	end

	`EXPTOK_ASSERT(a_load_when_free, !load || rem_q == '0 || (rem_q == CNT_W'(1) && fire), "result buffer overwritten while requests remain")
	`EXPTOK_ASSERT(a_last_marks_end, !tokens.valid || (tokens.last_of_run == (rem_q == CNT_W'(1))), "last_of_run does not match the final request of an item")
	`EXPTOK_ASSERT_NEXT(a_drain_continues, fire && rem_q > CNT_W'(1) && !load, tokens.valid, "pending requests lost after a transfer")

endmodule

`default_nettype wire

// ===== hdl/expression_tokenizer.sv =====
// Expression tokenizer: splits a character stream into lexical tokens.
// The chars channel takes one character per request, with end_of_string set on
// the last character of an expression. The tokens channel gives append,
// complete and error events; last_of_run marks the final event of a character.
// A character is held in an input register, decoded against the lexer mode
// and its zero to three events are loaded into a three-entry result buffer
// that drains one event per cycle while the tokens receiver is ready.
// The first event of a character is presented once the character has passed
// the input register and been loaded into the result buffer.
// Throughput: one character per cycle while each character gives at most one
// event and the tokens receiver is ready; a character with several events
// holds the result buffer until all are taken. Characters with no event (white
// space, characters after an error) pass at one per cycle while the buffer is free.
// Reset clears the lexer mode, pending operator, error flag and both registers.
// When the tokens receiver stalls, the result buffer holds its events, the input
// register holds the next character and chars.ready falls until space frees.
`timescale 1ns / 1ps
`default_nettype none

`include "expression_tokenizer_macros.svh"

module expression_tokenizer import exptok_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	exptok_char_if.sink  chars,
	exptok_tok_if.source tokens
);

	logic       vld_s1;
	logic [7:0] char_s1;
	logic       eos_s1;
	lex_state_t state_q;
	lex_state_t state_nxt;
	res_load_t  ld;
	logic       free;
	logic       advance;
	logic       accept;

	assign advance     = vld_s1 && free;
	assign chars.ready = !vld_s1 || free;
	assign accept      = chars.valid && chars.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (advance) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1 <= chars.character;
			eos_s1  <= chars.end_of_string;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{mode: MODE_IDLE, pend: OP_PLUS, err: 1'b0};
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	exptok_lex u_lex (
		.character     (char_s1),
		.end_of_string (eos_s1),
		.cur           (state_q),
		.nxt           (state_nxt),
		.ld            (ld)
	);

	exptok_rbuf u_rbuf (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance),
		.ld     (ld),
		.free   (free),
		.tokens (tokens)
	);

	`EXPTOK_ASSERT(a_silent_after_error, !(advance && state_q.err) || ld.cnt == '0, "events produced while the error flag is set")
	`EXPTOK_ASSERT_NEXT(a_eos_resets, advance && eos_s1, state_q.mode == MODE_IDLE && !state_q.err && state_q.pend == OP_PLUS, "lexer state not cleared after end of string")

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import exptok_pkg::*;

	typedef struct {
		logic [7:0] ch;
		logic       eos;
		int         send_gap;
		int         recv_stall;
		bit         drain;
	} char_req_t;

	logic clk = 1'b0;
	logic arst_n;

	exptok_char_if chars_if ();
	exptok_tok_if  tok_if ();

	expression_tokenizer u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_if),
		.tokens (tok_if)
	);

	char_req_t  char_q[$];
	res_t       token_q[$];
	logic [7:0] expr_buf[$];
	int         errors;
	int         stim_chars;
	int         send_gap;
	int         recv_stall;

	mode_t lx_mode;
	op_t   lx_pend;
	logic  lx_err;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic bit is_digit(logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic bit is_letter(logic [7:0] c);
		return (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z);
	endfunction

	function automatic bit is_word(logic [7:0] c);
		return is_digit(c) || is_letter(c) || c == CH_USCORE;
	endfunction

	function automatic bit is_white(logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_LF;
	endfunction

	function automatic bit is_oper(logic [7:0] c);
		return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH;
	endfunction

	function automatic op_t oper_of(logic [7:0] c);
		case (c)
			CH_PLUS:  return OP_PLUS;
			CH_MINUS: return OP_MINUS;
			CH_STAR:  return OP_MUL;
			default:  return OP_DIV;
		endcase
	endfunction

	function automatic void note_token(event_t ev, logic [7:0] ch, logic [3:0] ty);
		res_t r;
		r.ev = ev;
		r.ch = ch;
		r.ty = ty;
		r.last = 1'b0;
		token_q.push_back(r);
	endfunction

	function automatic logic [3:0] open_type();
		case (lx_mode)
			MODE_NAME: return TT_NAME;
			MODE_PATH: return TT_PATH;
			MODE_INT:  return TT_INT;
			MODE_REAL: return TT_REAL;
			default:   return TT_PLUS + 4'(lx_pend);
		endcase
	endfunction

	function automatic void close_open_token();
		note_token(EV_COMPLETE, CH_NUL, open_type());
		lx_mode = MODE_IDLE;
		lx_pend = OP_PLUS;
	endfunction

	function automatic void flag_bad_char(logic [7:0] c);
		note_token(EV_ERROR, c, TT_NONE);
		lx_mode = MODE_IDLE;
		lx_pend = OP_PLUS;
		lx_err = 1'b1;
	endfunction

	function automatic void start_token(logic [7:0] c);
		if (is_letter(c)) begin
			note_token(EV_APPEND, c, TT_NONE);
			lx_mode = MODE_NAME;
		end else if (is_digit(c)) begin
			note_token(EV_APPEND, c, TT_NONE);
			lx_mode = MODE_INT;
		end else if (is_oper(c)) begin
			note_token(EV_APPEND, c, TT_NONE);
			lx_mode = MODE_OPER;
			lx_pend = oper_of(c);
		end else if (is_white(c)) begin
		end else if (c == CH_LPAREN || c == CH_RPAREN || c == CH_DOT || c == CH_COMMA) begin
			note_token(EV_APPEND, c, TT_NONE);
			note_token(EV_COMPLETE, CH_NUL, c == CH_LPAREN ? TT_LPAREN :
				c == CH_RPAREN ? TT_RPAREN : c == CH_DOT ? TT_DOT : TT_COMMA);
		end else begin
			flag_bad_char(c);
		end
	endfunction

	function automatic void lex_char(logic [7:0] c);
		case (lx_mode)
			MODE_NAME: begin
				if (is_word(c)) begin
					note_token(EV_APPEND, c, TT_NONE);
				end else if (c == CH_SLASH) begin
					note_token(EV_APPEND, c, TT_NONE);
					lx_mode = MODE_PATH;
				end else begin
					close_open_token();
					start_token(c);
				end
			end
			MODE_PATH: begin
				if (is_word(c) || c == CH_SLASH) begin
					note_token(EV_APPEND, c, TT_NONE);
				end else begin
					close_open_token();
					start_token(c);
				end
			end
			MODE_INT, MODE_REAL: begin
				if (is_digit(c)) begin
					note_token(EV_APPEND, c, TT_NONE);
				end else if (lx_mode == MODE_INT && c == CH_DOT) begin
					note_token(EV_APPEND, c, TT_NONE);
					lx_mode = MODE_REAL;
				end else if (is_white(c) || c == CH_RPAREN || is_oper(c) || c == CH_COMMA) begin
					close_open_token();
					start_token(c);
				end else begin
					flag_bad_char(c);
				end
			end
			MODE_OPER: begin
				if (lx_pend == OP_DIV && is_word(c)) begin
					note_token(EV_APPEND, c, TT_NONE);
					lx_mode = MODE_PATH;
					lx_pend = OP_PLUS;
				end else begin
					close_open_token();
					start_token(c);
				end
			end
			default: begin
				lx_mode = MODE_IDLE;
				start_token(c);
			end
		endcase
	endfunction

	function automatic void tokenize_char(logic [7:0] c, logic eos);
		int   n0;
		res_t r;
		n0 = token_q.size();
		if (!lx_err) begin
			lex_char(c);
			if (eos && !lx_err && lx_mode != MODE_IDLE)
				close_open_token();
		end
		if (eos) begin
			lx_mode = MODE_IDLE;
			lx_pend = OP_PLUS;
			lx_err = 1'b0;
		end
		if (token_q.size() > n0) begin
			r = token_q.pop_back();
			r.last = 1'b1;
			token_q.push_back(r);
		end
	endfunction

	function automatic logic [7:0] rand_letter();
		if ($urandom_range(1))
			return 8'(CH_UPPER_A + $urandom_range(25));
		return 8'(CH_LOWER_A + $urandom_range(25));
	endfunction

	function automatic logic [7:0] rand_digit();
		return 8'(CH_ZERO + $urandom_range(9));
	endfunction

	function automatic logic [7:0] rand_word();
		case ($urandom_range(2))
			0:       return rand_letter();
			1:       return rand_digit();
			default: return CH_USCORE;
		endcase
	endfunction

	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++)
			expr_buf.push_back(s[i]);
	endtask

	task automatic add_rand_token();
		case ($urandom_range(9))
			0, 1: begin
				expr_buf.push_back(rand_letter());
				repeat ($urandom_range(4)) expr_buf.push_back(rand_word());
				if ($urandom_range(2) == 0) begin
					expr_buf.push_back(CH_SLASH);
					repeat ($urandom_range(3)) expr_buf.push_back(rand_word());
				end
			end
			2: repeat ($urandom_range(1, 4)) expr_buf.push_back(rand_digit());
			3: begin
				repeat ($urandom_range(1, 3)) expr_buf.push_back(rand_digit());
				expr_buf.push_back(CH_DOT);
				repeat ($urandom_range(3)) expr_buf.push_back(rand_digit());
			end
			4, 5: begin
				case ($urandom_range(3))
					0:       expr_buf.push_back(CH_PLUS);
					1:       expr_buf.push_back(CH_MINUS);
					2:       expr_buf.push_back(CH_STAR);
					default: expr_buf.push_back(CH_SLASH);
				endcase
			end
			6: expr_buf.push_back($urandom_range(1) ? CH_LPAREN : CH_RPAREN);
			7: expr_buf.push_back($urandom_range(1) ? CH_COMMA : CH_DOT);
			8: begin
				expr_buf.push_back(CH_SLASH);
				repeat ($urandom_range(1, 3)) expr_buf.push_back(rand_word());
			end
			default: begin
				case ($urandom_range(2))
					0:       expr_buf.push_back(CH_SPACE);
					1:       expr_buf.push_back(CH_TAB);
					default: expr_buf.push_back(CH_LF);
				endcase
			end
		endcase
	endtask

	task automatic gen_expr();
		int kind;
		kind = $urandom_range(99);
		if (kind < 10) begin
			repeat ($urandom_range(1, 6)) expr_buf.push_back(8'($urandom_range(255)));
		end else begin
			repeat ($urandom_range(1, 5)) begin
				add_rand_token();
				if ($urandom_range(1))
					expr_buf.push_back(CH_SPACE);
			end
			if (kind < 25)
				expr_buf[$urandom_range(expr_buf.size() - 1)] = 8'($urandom_range(255));
		end
	endtask

	task automatic flush_expr(int gap, int stall, bit drain);
		char_req_t q;
		for (int i = 0; i < expr_buf.size(); i++) begin
			q.ch = expr_buf[i];
			q.eos = (i == expr_buf.size() - 1);
			q.send_gap = gap;
			q.recv_stall = stall;
			q.drain = drain && i == 0;
			char_q.push_back(q);
			stim_chars++;
		end
		expr_buf.delete();
	endtask

	always @(posedge clk or negedge arst_n) begin : char_drive
		char_req_t nxt;
		bit        busy;
		if (!arst_n) begin
			chars_if.valid <= 1'b0;
			chars_if.character <= CH_NUL;
			chars_if.end_of_string <= 1'b0;
		end else begin
			busy = chars_if.valid && !chars_if.ready;
			if (chars_if.valid && chars_if.ready)
				tokenize_char(chars_if.character, chars_if.end_of_string);
			if (!busy) begin
				// A request marked for draining waits until every expected event is out.
				if (char_q.size() > 0 && $urandom_range(99) >= send_gap &&
						!(char_q[0].drain && token_q.size() != 0)) begin
					nxt = char_q.pop_front();
					chars_if.valid <= 1'b1;
					chars_if.character <= nxt.ch;
					chars_if.end_of_string <= nxt.eos;
					send_gap <= nxt.send_gap;
					recv_stall <= nxt.recv_stall;
				end else begin
					chars_if.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tok_if.ready <= 1'b0;
		else
			tok_if.ready <= $urandom_range(99) >= recv_stall;
	end

	always @(posedge clk) begin : tok_check
		res_t want;
		if (arst_n && tok_if.valid && tok_if.ready) begin
			if (token_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected event, expected none, got ev=%0d ch=%02h ty=%0d last=%0b",
					$time, tok_if.event_res, tok_if.token_char, tok_if.token_type,
					tok_if.last_of_run);
			end else begin
				want = token_q.pop_front();
				if (tok_if.event_res !== want.ev) begin
					errors++;
					$display("%0t: event_res expected %0d got %0d", $time, want.ev,
						tok_if.event_res);
				end
				if (tok_if.token_char !== want.ch) begin
					errors++;
					$display("%0t: token_char expected %02h got %02h", $time, want.ch,
						tok_if.token_char);
				end
				if (tok_if.token_type !== want.ty) begin
					errors++;
					$display("%0t: token_type expected %0d got %0d", $time, want.ty,
						tok_if.token_type);
				end
				if (tok_if.last_of_run !== want.last) begin
					errors++;
					$display("%0t: last_of_run expected %0b got %0b", $time, want.last,
						tok_if.last_of_run);
				end
			end
		end
	end

	initial begin
		int gap_tab[5];
		int stall_tab[5];
		bit first;
		gap_tab = '{0, 87, 0, 23, 0};
		stall_tab = '{0, 0, 87, 23, 0};
		arst_n = 1'b0;
		chars_if.valid = 1'b0;
		chars_if.character = CH_NUL;
		chars_if.end_of_string = 1'b0;
		tok_if.ready = 1'b0;
		errors = 0;
		stim_chars = 0;
		send_gap = 0;
		recv_stall = 0;
		lx_mode = MODE_IDLE;
		lx_pend = OP_PLUS;
		lx_err = 1'b0;

		add_text("Zz/_1+");
		flush_expr(0, 0, 1'b1);
		add_text("9.0.");
		expr_buf.push_back(8'hFF);
		flush_expr(0, 0, 1'b0);
		add_text("/q*3)");
		expr_buf.push_back(CH_TAB);
		flush_expr(0, 0, 1'b0);
		expr_buf.push_back(CH_NUL);
		flush_expr(0, 0, 1'b0);
		expr_buf.push_back(8'hFF);
		add_text("a");
		flush_expr(0, 0, 1'b0);
		add_text("7a");
		flush_expr(0, 0, 1'b0);
		expr_buf.push_back(CH_LF);
		flush_expr(0, 0, 1'b0);
		add_text("(-x,");
		flush_expr(0, 0, 1'b0);

		stim_chars = 0;
		for (int ph = 0; ph < 5; ph++) begin
			first = 1'b1;
			while (stim_chars < (ph + 1) * 36) begin
				gen_expr();
				flush_expr(gap_tab[ph], stall_tab[ph], first || $urandom_range(19) == 0);
				first = 1'b0;
			end
		end

		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		while (char_q.size() != 0 || chars_if.valid)
			@(posedge clk);
		while (token_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("PASS expression_tokenizer");
		else
			$display("FAIL expression_tokenizer");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("FAIL expression_tokenizer");
		$finish;
	end

endmodule

// ===== expression_tokenizer.f =====
+incdir+hdl
hdl/exptok_pkg.sv
hdl/exptok_char_if.sv
hdl/exptok_tok_if.sv
hdl/exptok_lex.sv
hdl/exptok_rbuf.sv
hdl/expression_tokenizer.sv
tb/tb.sv
